FILE: sv/epos_pkg.sv
// Shared types, codes and defaults for the eased position trajectory unit.
package epos_pkg;

    localparam int POS_WIDTH_DEF       = 24;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int OFS_W               = 24;
    localparam int KIND_W              = 2;
    localparam int CFG_ADDR_W          = 5;
    localparam int CFG_DATA_W          = 32;
    localparam int REG_IDX_W           = 3;

    typedef enum logic [2:0] {
        MODE_LINEAR,
        MODE_QUAD_BEZ,
        MODE_QUAD_IN,
        MODE_QUAD_OUT,
        MODE_CUBIC_BEZ,
        MODE_CUBIC_IN,
        MODE_CUBIC_OUT,
        MODE_SMOOTH
    } t_mode;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MODE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFS1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFS2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFS3 = 3'd4;

    typedef struct packed {
        t_mode             mode;
        logic [OFS_W-1:0]  off_one;
        logic [OFS_W-1:0]  off_two;
        logic [OFS_W-1:0]  off_three;
    } t_curve_cfg;

endpackage

FILE: sv/epos_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module epos_serial_mul #(
    parameter int MCAND_W  = epos_pkg::OFS_W + 2,
    parameter int MPLIER_W = epos_pkg::PHASE_FRAC_BITS_DEF + 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [MCAND_W-1:0]            i_mcand,
    input  logic        [MPLIER_W-1:0]           i_mplier,
    output logic                                 o_done,
    output logic signed [MCAND_W+MPLIER_W-1:0]   o_prod
);

    localparam int PRW   = MCAND_W + MPLIER_W;
    localparam int CNT_W = $clog2(MPLIER_W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(MPLIER_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic [CNT_W-1:0]        r_cnt;
    logic                    r_done;
    logic signed [PRW-1:0]   r_acc;
    logic signed [PRW-1:0]   r_mc;
    logic [MPLIER_W-1:0]     r_mp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_acc <= '0;
                r_mc  <= PRW'(i_mcand);
                r_mp  <= i_mplier;
                r_cnt <= CNT_LOAD;
            end else if (r_cnt != '0) begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= r_mc <<< 1;
                r_mp  <= r_mp >> 1;
                r_cnt <= r_cnt - CNT_LAST;
                if (r_cnt == CNT_LAST) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: sv/epos_cfg.sv
// APB register file: motion mode, phase step and control point offsets.
module epos_cfg #(
    parameter int PHASE_FRAC_BITS = epos_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epos_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [epos_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [epos_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output epos_pkg::t_curve_cfg                o_cfg,
    output logic [PHASE_FRAC_BITS:0]            o_phase_step
);

    localparam int TW = PHASE_FRAC_BITS + 1;
    localparam logic [TW-1:0] STEP_RESET = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
    localparam int PAD_W = epos_pkg::CFG_DATA_W - epos_pkg::OFS_W;

    epos_pkg::t_curve_cfg                  r_cfg;
    logic [TW-1:0]                         r_step;
    logic [epos_pkg::REG_IDX_W-1:0]        reg_idx;
    logic                                  wr_en;

    assign reg_idx = paddr[epos_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= epos_pkg::MODE_LINEAR;
            r_cfg.off_one   <= '0;
            r_cfg.off_two   <= '0;
            r_cfg.off_three <= '0;
            r_step          <= STEP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                epos_pkg::REG_MODE: r_cfg.mode      <= epos_pkg::t_mode'(pwdata[2:0]);
                epos_pkg::REG_STEP: r_step          <= pwdata[TW-1:0];
                epos_pkg::REG_OFS1: r_cfg.off_one   <= pwdata[epos_pkg::OFS_W-1:0];
                epos_pkg::REG_OFS2: r_cfg.off_two   <= pwdata[epos_pkg::OFS_W-1:0];
                epos_pkg::REG_OFS3: r_cfg.off_three <= pwdata[epos_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            epos_pkg::REG_MODE: prdata = epos_pkg::CFG_DATA_W'(r_cfg.mode);
            epos_pkg::REG_STEP: prdata = epos_pkg::CFG_DATA_W'(r_step);
            epos_pkg::REG_OFS1: prdata = {{PAD_W{1'b0}}, r_cfg.off_one};
            epos_pkg::REG_OFS2: prdata = {{PAD_W{1'b0}}, r_cfg.off_two};
            epos_pkg::REG_OFS3: prdata = {{PAD_W{1'b0}}, r_cfg.off_three};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg        = r_cfg;
    assign o_phase_step = r_step;

endmodule

FILE: sv/epos_curve.sv
// Curve sequencer: weight and point products on the serial multiplier, sum and saturate.
module epos_curve #(
    parameter int POS_WIDTH       = epos_pkg::POS_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = epos_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [PHASE_FRAC_BITS:0]      i_phase,
    input  logic signed [POS_WIDTH-1:0]   i_start_point,
    input  epos_pkg::t_curve_cfg          i_cfg,
    output logic                          o_done,
    output logic signed [POS_WIDTH-1:0]   o_position
);

    localparam int F   = PHASE_FRAC_BITS;
    localparam int TW  = F + 1;
    localparam int WW  = F + 3;
    localparam int PTW = ((POS_WIDTH > epos_pkg::OFS_W) ? POS_WIDTH : epos_pkg::OFS_W) + 2;
    localparam int MW  = (PTW > WW + 1) ? PTW : WW + 1;
    localparam int PRW = MW + WW;
    localparam int AW  = PRW + 3;

    localparam logic [TW-1:0] ONE_T = {1'b1, {F{1'b0}}};
    localparam logic [WW-1:0] ONE_W = {2'b00, ONE_T};
    localparam logic signed [AW-1:0] SAT_HI =
        {{(AW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO =
        {{(AW - POS_WIDTH + 1){1'b1}}, {(POS_WIDTH - 1){1'b0}}};

    typedef enum logic [3:0] {
        STP_IDLE,
        STP_T2,
        STP_T3,
        STP_U2,
        STP_U3,
        STP_TU,
        STP_TU2,
        STP_T2U,
        STP_TERM0,
        STP_TERM1,
        STP_TERM2,
        STP_TERM3,
        STP_FIN
    } t_step;

    t_step                    r_step;
    logic                     r_issue;
    logic                     r_done;
    logic signed [POS_WIDTH-1:0] r_pos;
    logic [TW-1:0]            r_t, r_u, r_t2, r_t3, r_u2, r_u3, r_tu, r_tu2, r_t2u;
    logic signed [PTW-1:0]    r_p0, r_p1, r_p2, r_p3;
    logic signed [AW-1:0]     r_acc;

    logic signed [MW-1:0]     mul_mcand;
    logic [WW-1:0]            mul_mplier;
    logic                     mul_done;
    logic signed [PRW-1:0]    mul_prod;
    logic [TW-1:0]            wt;
    logic [WW-1:0]            w_ease;
    logic                     is_quad, is_cubic, is_ease;
    logic signed [PTW-1:0]    d1, d2, d3;
    logic signed [AW-1:0]     acc_shift;
    logic signed [POS_WIDTH-1:0] n_pos;

    epos_serial_mul #(
        .MCAND_W  (MW),
        .MPLIER_W (WW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_issue),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    assign wt       = mul_prod[F +: TW];
    assign is_quad  = (i_cfg.mode == epos_pkg::MODE_QUAD_BEZ);
    assign is_cubic = (i_cfg.mode == epos_pkg::MODE_CUBIC_BEZ);
    assign is_ease  = !is_quad && !is_cubic;
    assign d1       = PTW'($signed(i_cfg.off_one));
    assign d2       = PTW'($signed(i_cfg.off_two));
    assign d3       = PTW'($signed(i_cfg.off_three));

    always_comb begin
        case (i_cfg.mode)
            epos_pkg::MODE_LINEAR:    w_ease = WW'(r_t);
            epos_pkg::MODE_QUAD_IN:   w_ease = WW'(r_t2);
            epos_pkg::MODE_QUAD_OUT:  w_ease = ONE_W - WW'(r_u2);
            epos_pkg::MODE_CUBIC_IN:  w_ease = WW'(r_t3);
            epos_pkg::MODE_CUBIC_OUT: w_ease = ONE_W - WW'(r_u3);
            epos_pkg::MODE_SMOOTH:    w_ease = WW'(r_t2) + (WW'(r_t2) << 1) - (WW'(r_t3) << 1);
            default:                  w_ease = '0;
        endcase
    end

    always_comb begin
        mul_mcand  = '0;
        mul_mplier = '0;
        case (r_step)
            STP_T2:  begin mul_mcand = MW'(r_t);  mul_mplier = WW'(r_t); end
            STP_T3:  begin mul_mcand = MW'(r_t2); mul_mplier = WW'(r_t); end
            STP_U2:  begin mul_mcand = MW'(r_u);  mul_mplier = WW'(r_u); end
            STP_U3:  begin mul_mcand = MW'(r_u2); mul_mplier = WW'(r_u); end
            STP_TU:  begin mul_mcand = MW'(r_t);  mul_mplier = WW'(r_u); end
            STP_TU2: begin mul_mcand = MW'(r_t);  mul_mplier = WW'(r_u2); end
            STP_T2U: begin mul_mcand = MW'(r_t2); mul_mplier = WW'(r_u); end
            STP_TERM0: begin
                if (is_quad) begin
                    mul_mcand = MW'(r_p0); mul_mplier = WW'(r_u2);
                end else if (is_cubic) begin
                    mul_mcand = MW'(r_p0); mul_mplier = WW'(r_u3);
                end else begin
                    mul_mcand = MW'(d1);   mul_mplier = w_ease;
                end
            end
            STP_TERM1: begin
                mul_mcand = MW'(r_p1);
                if (is_quad) begin
                    mul_mplier = WW'(r_tu) << 1;
                end else if (is_cubic) begin
                    mul_mplier = WW'(r_tu2) + (WW'(r_tu2) << 1);
                end
            end
            STP_TERM2: begin
                mul_mcand = MW'(r_p2);
                if (is_quad) begin
                    mul_mplier = WW'(r_t2);
                end else if (is_cubic) begin
                    mul_mplier = WW'(r_t2u) + (WW'(r_t2u) << 1);
                end
            end
            STP_TERM3: begin
                mul_mcand = MW'(r_p3);
                if (is_cubic) begin
                    mul_mplier = WW'(r_t3);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        acc_shift = r_acc >>> F;
        if (acc_shift > SAT_HI) begin
            n_pos = SAT_HI[POS_WIDTH-1:0];
        end else if (acc_shift < SAT_LO) begin
            n_pos = SAT_LO[POS_WIDTH-1:0];
        end else begin
            n_pos = acc_shift[POS_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STP_IDLE;
            r_issue <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_issue <= 1'b0;
            r_done  <= 1'b0;
            case (r_step)
                STP_IDLE: begin
                    if (i_start) begin
                        r_t     <= i_phase;
                        r_u     <= ONE_T - i_phase;
                        r_p0    <= PTW'(i_start_point);
                        r_step  <= STP_T2;
                        r_issue <= 1'b1;
                    end
                end
                STP_T2: if (mul_done) begin
                    r_t2 <= wt; r_p1 <= r_p0 + d1; r_step <= STP_T3; r_issue <= 1'b1;
                end
                STP_T3: if (mul_done) begin
                    r_t3 <= wt; r_p2 <= r_p1 + d2; r_step <= STP_U2; r_issue <= 1'b1;
                end
                STP_U2: if (mul_done) begin
                    r_u2 <= wt; r_p3 <= r_p2 + d3; r_step <= STP_U3; r_issue <= 1'b1;
                end
                STP_U3: if (mul_done) begin
                    r_u3 <= wt; r_step <= STP_TU; r_issue <= 1'b1;
                end
                STP_TU: if (mul_done) begin
                    r_tu <= wt; r_step <= STP_TU2; r_issue <= 1'b1;
                end
                STP_TU2: if (mul_done) begin
                    r_tu2 <= wt; r_step <= STP_T2U; r_issue <= 1'b1;
                end
                STP_T2U: if (mul_done) begin
                    r_t2u   <= wt;
                    r_acc   <= is_ease ? (AW'(r_p0) <<< F) : '0;
                    r_step  <= STP_TERM0;
                    r_issue <= 1'b1;
                end
                STP_TERM0: if (mul_done) begin
                    r_acc <= r_acc + AW'(mul_prod); r_step <= STP_TERM1; r_issue <= 1'b1;
                end
                STP_TERM1: if (mul_done) begin
                    r_acc <= r_acc + AW'(mul_prod); r_step <= STP_TERM2; r_issue <= 1'b1;
                end
                STP_TERM2: if (mul_done) begin
                    r_acc <= r_acc + AW'(mul_prod); r_step <= STP_TERM3; r_issue <= 1'b1;
                end
                STP_TERM3: if (mul_done) begin
                    r_acc <= r_acc + AW'(mul_prod); r_step <= STP_FIN;
                end
                STP_FIN: begin
                    r_pos  <= n_pos;
                    r_done <= 1'b1;
                    r_step <= STP_IDLE;
                end
                default: r_step <= STP_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_position = r_pos;

endmodule

FILE: sv/eased_position_trajectory_unit.sv
// Top level of the one-axis eased position trajectory unit.
// A frame tick during a move runs eleven products in turn on one bit-serial multiplier.
// Every other item goes straight to the push state, where its result is registered unless the output stalls.
// One item at a time; the next item is accepted the cycle after the result is registered.
// Synchronous active-low reset clears the axis state, the result valid flag and the registers.
module eased_position_trajectory_unit #(
    parameter int POS_WIDTH       = epos_pkg::POS_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = epos_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [epos_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [epos_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [epos_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [epos_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [POS_WIDTH-1:0]         i_new_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [POS_WIDTH-1:0]         o_position_out,
    output logic [PHASE_FRAC_BITS:0]            o_phase_out,
    output logic                                o_moving
);

    localparam int TW = PHASE_FRAC_BITS + 1;
    localparam logic [TW-1:0] ONE_T = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
    localparam logic [TW:0]   ONE_S = {2'b01, {PHASE_FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PUSH
    } t_state;

    t_state                     r_state;
    logic signed [POS_WIDTH-1:0] r_position;
    logic signed [POS_WIDTH-1:0] r_start_point;
    logic [TW-1:0]              r_phase;
    logic                       r_active;
    logic                       r_curve_start;
    logic                       r_out_valid;
    logic signed [POS_WIDTH-1:0] r_out_pos;
    logic [TW-1:0]              r_out_phase;
    logic                       r_out_moving;

    epos_pkg::t_curve_cfg       cfg;
    logic [TW-1:0]              phase_step;
    logic                       curve_done;
    logic signed [POS_WIDTH-1:0] curve_pos;
    logic [TW:0]                n_sum;
    logic [TW-1:0]              n_phase;
    logic                       n_stop;

    epos_cfg #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_cfg        (cfg),
        .o_phase_step (phase_step)
    );

    epos_curve #(
        .POS_WIDTH       (POS_WIDTH),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_curve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_curve_start),
        .i_phase       (r_phase),
        .i_start_point (r_start_point),
        .i_cfg         (cfg),
        .o_done        (curve_done),
        .o_position    (curve_pos)
    );

    always_comb begin
        n_sum   = {1'b0, r_phase} + {1'b0, phase_step};
        n_phase = (n_sum > ONE_S) ? ONE_T : n_sum[TW-1:0];
        n_stop  = (({1'b0, n_phase} + {1'b0, phase_step}) >= ONE_S);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_position    <= '0;
            r_start_point <= '0;
            r_phase       <= '0;
            r_active      <= 1'b0;
            r_curve_start <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_curve_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_PUSH;
                        case (i_kind)
                            epos_pkg::KIND_TICK: begin
                                if (r_active) begin
                                    r_phase       <= n_phase;
                                    r_active      <= !n_stop;
                                    r_curve_start <= 1'b1;
                                    r_state       <= ST_EVAL;
                                end
                            end
                            epos_pkg::KIND_BEGIN: begin
                                r_start_point <= r_position;
                                r_phase       <= '0;
                                r_active      <= 1'b1;
                            end
                            epos_pkg::KIND_SET: begin
                                r_start_point <= r_position;
                                r_phase       <= '0;
                                r_active      <= 1'b0;
                                r_position    <= i_new_position;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_EVAL: begin
                    if (curve_done) begin
                        r_position <= curve_pos;
                        r_state    <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_pos    <= r_position;
                        r_out_phase  <= r_phase;
                        r_out_moving <= r_active;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_position_out = r_out_pos;
    assign o_phase_out    = r_out_phase;
    assign o_moving       = r_out_moving;

endmodule

FILE: sv/epos_check.sv
// Port-level checker for the eased position trajectory unit, with its bind.
module epos_check #(
    parameter int POS_WIDTH       = epos_pkg::POS_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = epos_pkg::PHASE_FRAC_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [POS_WIDTH-1:0]        o_position_out,
    input logic [PHASE_FRAC_BITS:0]    o_phase_out,
    input logic                        o_moving
);

    localparam logic [PHASE_FRAC_BITS:0] ONE_T = {1'b1, {PHASE_FRAC_BITS{1'b0}}};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transaction");

    a_moving_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_moving |-> o_phase_out < ONE_T)
        else $error("move reported with phase at one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_position_out) && $stable(o_phase_out) && $stable(o_moving))
        else $error("result changed while stalled");

endmodule

bind eased_position_trajectory_unit epos_check #(
    .POS_WIDTH       (POS_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
) u_epos_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_position_out (o_position_out),
    .o_phase_out    (o_phase_out),
    .o_moving       (o_moving)
);
